/* hw/rtl/quadrature_speed_meter_macros.svh */
// assertion macros for the quadrature speed meter
`ifndef QUADRATURE_SPEED_METER_MACROS_SVH
`define QUADRATURE_SPEED_METER_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define QSM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qsm assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define QSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qsm assertion failed");

`endif

/* hw/rtl/qsm_pkg.sv */
// shared types and constants of the quadrature speed meter
`timescale 1ns / 1ps
`default_nettype none
package qsm_pkg;

  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;
  localparam int IDX_W     = ADDR_W - 2;
  localparam int DIV_STEPS = 2 * DATA_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [IDX_W-1:0]  REG_CONV_FACTOR = '0;
  localparam logic [DATA_W-1:0] FACTOR_RESET    = 32'd1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  typedef struct packed {
    logic edge_upd;
    logic read_cap;
    logic mul;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic elapsed_zero;
    logic div_last;
  } stat_t;

endpackage
`default_nettype wire

/* hw/rtl/qsm_ctrl.sv */
// controller state machine of the quadrature speed meter
`timescale 1ns / 1ps
`default_nettype none
`include "quadrature_speed_meter_macros.svh"
module qsm_ctrl
  import qsm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  wire logic  in_op,
  output logic       in_stall,
  output logic       out_valid,
  input  wire logic  out_stall,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.edge_upd = in_acc && !in_op;
    cmd.read_cap = in_acc && in_op;
    cmd.mul      = (state_r == S_MUL);
    cmd.div_step = (state_r == S_DIV);
    cmd.out_load = (state_r == S_DONE) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.read_cap) state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = stat.elapsed_zero ? S_DONE : S_DIV;
      end
      S_DIV: begin
        if (stat.div_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `QSM_ASSERT_NEXT(a_read_starts_mul, cmd.read_cap, state_r == S_MUL)
  `QSM_ASSERT_NEXT(a_div_runs_on, (state_r == S_DIV) && !stat.div_last, state_r == S_DIV)
  `QSM_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_valid_r || !out_stall)

endmodule
`default_nettype wire

/* hw/rtl/qsm_dp.sv */
// datapath of the quadrature speed meter: step count, multiply, divide, saturate
`timescale 1ns / 1ps
`default_nettype none
module qsm_dp
  import qsm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cmd_t              cmd,
  output stat_t                  stat,
  input  wire logic              in_level_a,
  input  wire logic              in_level_b,
  input  wire logic [DATA_W-1:0] in_now_us,
  input  wire logic [DATA_W-1:0] factor,
  output logic signed [DATA_W-1:0] out_speed,
  output logic                   out_time_error
);

  logic                  prev_a_r, prev_a_nxt;
  logic [DATA_W-1:0]     step_count_r, step_count_nxt;
  logic [DATA_W-1:0]     last_time_r, last_time_nxt;
  logic [DATA_W-1:0]     cnt_mag_r;
  logic [DATA_W-1:0]     ela_mag_r;
  logic                  neg_r;
  logic                  err_r;
  logic [DATA_W-1:0]     rem_r;
  logic [2*DATA_W-1:0]   dq_r;
  logic [STEP_W-1:0]     step_r;
  logic [DATA_W-1:0]     speed_r;
  logic                  time_error_r;

  logic [DATA_W-1:0]     elapsed;
  logic [2*DATA_W-1:0]   prod;
  logic [DATA_W:0]       shifted;
  logic [DATA_W+1:0]     diff;
  logic                  ge;
  logic                  ovf_pos, ovf_neg;
  logic [DATA_W-1:0]     speed_nxt;

  assign elapsed = in_now_us - last_time_r;
  assign prod    = {{DATA_W{1'b0}}, cnt_mag_r} * {{DATA_W{1'b0}}, factor};
  assign shifted = {rem_r, dq_r[2*DATA_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, ela_mag_r};
  assign ge      = !diff[DATA_W+1];

  assign stat.elapsed_zero = err_r;
  assign stat.div_last     = (step_r == STEP_W'(DIV_STEPS - 1));

  // edge event and read-side clearing of the count
  always_comb begin
    prev_a_nxt     = prev_a_r;
    step_count_nxt = step_count_r;
    last_time_nxt  = last_time_r;
    if (cmd.edge_upd) begin
      prev_a_nxt = in_level_a;
      if (in_level_b ^ prev_a_r) step_count_nxt = step_count_r + DATA_W'(1);
      else step_count_nxt = step_count_r - DATA_W'(1);
    end else if (cmd.read_cap) begin
      step_count_nxt = '0;
      last_time_nxt  = in_now_us;
    end
  end

  // saturate the signed quotient to 32 bits
  always_comb begin
    ovf_pos = |dq_r[2*DATA_W-1:DATA_W-1];
    ovf_neg = (|dq_r[2*DATA_W-1:DATA_W]) || (dq_r[DATA_W-1] && (|dq_r[DATA_W-2:0]));
    if (neg_r) speed_nxt = ovf_neg ? {1'b1, {(DATA_W-1){1'b0}}} : -dq_r[DATA_W-1:0];
    else speed_nxt = ovf_pos ? {1'b0, {(DATA_W-1){1'b1}}} : dq_r[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_a_r     <= 1'b0;
      step_count_r <= '0;
      last_time_r  <= '0;
    end else begin
      prev_a_r     <= prev_a_nxt;
      step_count_r <= step_count_nxt;
      last_time_r  <= last_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_cap) begin
      cnt_mag_r <= step_count_r[DATA_W-1] ? -step_count_r : step_count_r;
      ela_mag_r <= elapsed[DATA_W-1] ? -elapsed : elapsed;
      neg_r     <= step_count_r[DATA_W-1] ^ elapsed[DATA_W-1];
      err_r     <= (elapsed == '0);
    end
    if (cmd.mul) begin
      dq_r   <= prod;
      rem_r  <= '0;
      step_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      dq_r   <= {dq_r[2*DATA_W-2:0], ge};
      step_r <= step_r + STEP_W'(1);
    end
    if (cmd.out_load) begin
      speed_r      <= err_r ? '0 : speed_nxt;
      time_error_r <= err_r;
    end
  end

  assign out_speed      = signed'(speed_r);
  assign out_time_error = time_error_r;

endmodule
`default_nettype wire

/* hw/rtl/quadrature_speed_meter.sv */
// top level of the quadrature speed meter: register port, controller and datapath
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_op, in_level_a, in_level_b, in_now_us
//   out_     output     out_valid/out_stall out_speed, out_time_error
//   apb      input      psel/penable/pready paddr, pwdata, prdata
//
// edge events may arrive in every cycle while no speed read holds the input
// a speed read holds the input through capture, one 32x32 multiply,
// 64 steps of a one-bit-per-cycle restoring divider and output load
// a read with zero elapsed time skips the divider
// a finished read waits in its last state while out_stall holds the previous result
// synchronous reset clears count, previous level, timestamp and factor (to 1) at once
`timescale 1ns / 1ps
`default_nettype none
module quadrature_speed_meter
  import qsm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_op,
  input  wire logic                in_level_a,
  input  wire logic                in_level_b,
  input  wire logic [DATA_W-1:0]   in_now_us,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [DATA_W-1:0] out_speed,
  output logic                     out_time_error,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  logic [DATA_W-1:0] factor_r, factor_nxt;
  logic              hit;
  cmd_t              cmd;
  stat_t             stat;

  assign pready = 1'b1;
  assign hit    = (paddr[ADDR_W-1:2] == REG_CONV_FACTOR);
  assign prdata = hit ? factor_r : '0;

  always_comb begin
    factor_nxt = factor_r;
    if (psel && penable && pwrite && hit) factor_nxt = pwdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) factor_r <= FACTOR_RESET;
    else factor_r <= factor_nxt;
  end

  qsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  qsm_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_level_a     (in_level_a),
    .in_level_b     (in_level_b),
    .in_now_us      (in_now_us),
    .factor         (factor_r),
    .out_speed      (out_speed),
    .out_time_error (out_time_error)
  );

endmodule
`default_nettype wire

/* dv/quadrature_speed_meter_tb.sv */
// testbench of the quadrature speed meter: directed table, random encoder traffic, predictor
`timescale 1ns / 1ps
module quadrature_speed_meter_tb;
  import qsm_pkg::*;

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_READ = 1'b1;
  localparam logic [ADDR_W-1:0] ADDR_FACTOR = ADDR_W'({REG_CONV_FACTOR, 2'b00});
  localparam logic [ADDR_W-1:0] ADDR_SPARE  = 3'd4;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 400000;
  localparam longint SPEED_MAX = 64'sh7FFFFFFF;
  localparam longint SPEED_MIN = -64'sh80000000;
  localparam logic signed [31:0] SAT_HI = 32'sh7FFFFFFF;
  localparam logic signed [31:0] SAT_LO = 32'sh80000000;
  localparam logic [1:0] GRAY [4] = '{2'b00, 2'b01, 2'b11, 2'b10};

  typedef enum logic [1:0] {ROW_EDGE, ROW_READ, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic signed [31:0] speed;
    logic               time_error;
  } speed_res_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [ADDR_W-1:0]  addr;
    logic               a;
    logic               b;
    logic [31:0]        val;
    logic               typed;
    logic signed [31:0] t_speed;
    logic               t_err;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_op = 1'b0;
  logic in_level_a = 1'b0;
  logic in_level_b = 1'b0;
  logic [DATA_W-1:0] in_now_us = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_speed;
  logic out_time_error;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  quadrature_speed_meter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_level_a(in_level_a), .in_level_b(in_level_b), .in_now_us(in_now_us),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_speed(out_speed), .out_time_error(out_time_error),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [31:0] m_factor = FACTOR_RESET;
  logic        m_prev_a = 1'b0;
  logic [31:0] m_count = '0;
  logic [31:0] m_last_time = '0;

  speed_res_t speed_expect[$];
  int mismatches = 0;
  int cycles = 0;
  bit no_idle = 1'b0;
  int gap_pct = 30;
  int stall_pct = 15;
  int stall_left = 0;

  stim_row_t dir_rows [0:23] = '{
    '{ROW_READ, ADDR_FACTOR, 1'b0, 1'b0, 32'd0,         1'b1, 32'sd0, 1'b1},
    '{ROW_EDGE, ADDR_FACTOR, 1'b0, 1'b1, 32'hFFFFFFFF,  1'b0, 32'sd0, 1'b0},
    '{ROW_EDGE, ADDR_FACTOR, 1'b1, 1'b0, 32'd0,         1'b0, 32'sd0, 1'b0},
    '{ROW_EDGE, ADDR_FACTOR, 1'b1, 1'b0, 32'd0,         1'b0, 32'sd0, 1'b0},
    '{ROW_EDGE, ADDR_FACTOR, 1'b0, 1'b1, 32'd0,         1'b0, 32'sd0, 1'b0},
    '{ROW_EDGE, ADDR_FACTOR, 1'b0, 1'b1, 32'd0,         1'b0, 32'sd0, 1'b0},
    '{ROW_READ, ADDR_FACTOR, 1'b1, 1'b1, 32'd100,       1'b0, 32'sd0, 1'b0},
    '{ROW_CFG,  ADDR_FACTOR, 1'b0, 1'b0, 32'hFFFFFFFF,  1'b0, 32'sd0, 1'b0},
    '{ROW_EDGE, ADDR_FACTOR, 1'b0, 1'b1, 32'd0,         1'b0, 32'sd0, 1'b0},
    '{ROW_READ, ADDR_FACTOR, 1'b0, 1'b0, 32'd101,       1'b1, SAT_HI, 1'b0},
    '{ROW_EDGE, ADDR_FACTOR, 1'b0, 1'b0, 32'd0,         1'b0, 32'sd0, 1'b0},
    '{ROW_READ, ADDR_FACTOR, 1'b0, 1'b0, 32'd102,       1'b1, SAT_LO, 1'b0},
    '{ROW_READ, ADDR_FACTOR, 1'b0, 1'b0, 32'd102,       1'b1, 32'sd0, 1'b1},
    '{ROW_EDGE, ADDR_FACTOR, 1'b1, 1'b1, 32'd0,         1'b0, 32'sd0, 1'b0},
    '{ROW_READ, ADDR_FACTOR, 1'b0, 1'b0, 32'h80000066,  1'b0, 32'sd0, 1'b0},
    '{ROW_EDGE, ADDR_FACTOR, 1'b1, 1'b0, 32'd0,         1'b0, 32'sd0, 1'b0},
    '{ROW_READ, ADDR_FACTOR, 1'b0, 1'b0, 32'h00000065,  1'b0, 32'sd0, 1'b0},
    '{ROW_CFG,  ADDR_SPARE,  1'b0, 1'b0, 32'd5,         1'b0, 32'sd0, 1'b0},
    '{ROW_CFG,  ADDR_FACTOR, 1'b0, 1'b0, 32'd0,         1'b0, 32'sd0, 1'b0},
    '{ROW_EDGE, ADDR_FACTOR, 1'b0, 1'b0, 32'd0,         1'b0, 32'sd0, 1'b0},
    '{ROW_READ, ADDR_FACTOR, 1'b0, 1'b0, 32'hFFFFFFFF,  1'b0, 32'sd0, 1'b0},
    '{ROW_CFG,  ADDR_FACTOR, 1'b0, 1'b0, 32'd1,         1'b0, 32'sd0, 1'b0},
    '{ROW_EDGE, ADDR_FACTOR, 1'b1, 1'b1, 32'd0,         1'b0, 32'sd0, 1'b0},
    '{ROW_READ, ADDR_FACTOR, 1'b0, 1'b0, 32'hFFFFFFFF,  1'b1, 32'sd0, 1'b1}
  };

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic void speed_predict(input logic op, input logic a, input logic b,
                                        input logic [31:0] now, output logic has_res,
                                        output speed_res_t res);
    longint cnt;
    longint elapsed;
    longint prod;
    longint quot;
    logic [31:0] dt;
    has_res = 1'b0;
    res = '0;
    if (op == OP_EDGE) begin
      if ((b ^ m_prev_a) != 1'b0) m_count = m_count + 32'd1;
      else m_count = m_count - 32'd1;
      m_prev_a = a;
    end else begin
      has_res = 1'b1;
      dt = now - m_last_time;
      cnt = longint'(int'(m_count));
      elapsed = longint'(int'(dt));
      if (elapsed == 0) begin
        res.speed = '0;
        res.time_error = 1'b1;
      end else begin
        prod = cnt * longint'({32'b0, m_factor});
        quot = prod / elapsed;
        if (quot > SPEED_MAX) quot = SPEED_MAX;
        if (quot < SPEED_MIN) quot = SPEED_MIN;
        res.speed = quot[31:0];
        res.time_error = 1'b0;
      end
      m_count = '0;
      m_last_time = now;
    end
  endfunction

  task automatic send_req(input logic op, input logic a, input logic b, input logic [31:0] now,
                          input logic typed, input logic signed [31:0] t_speed,
                          input logic t_err);
    logic has_res;
    speed_res_t res;
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_level_a <= a;
    in_level_b <= b;
    in_now_us <= now;
    do @(posedge clk); while (in_stall);
    speed_predict(op, a, b, now, has_res, res);
    if (has_res) begin
      if (typed) begin
        res.speed = t_speed;
        res.time_error = t_err;
      end
      speed_expect.push_back(res);
    end
  endtask

  // register write while the block is idle, then read the factor back
  task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    in_valid <= 1'b0;
    while (speed_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_FACTOR) m_factor = data;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_FACTOR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== m_factor)
      report_mismatch($sformatf("factor readback %h, want %h", prdata, m_factor));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("quadrature_speed_meter_tb: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!no_idle && stall_left == 0 && $urandom_range(0, 99) < stall_pct)
      stall_left = $urandom_range(1, 10);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    speed_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (speed_expect.size() == 0) begin
        report_mismatch($sformatf("unexpected result speed %0d", out_speed));
      end else begin
        want = speed_expect.pop_front();
        if (out_speed !== want.speed)
          report_mismatch($sformatf("speed %0d, want %0d", out_speed, want.speed));
        if (out_time_error !== want.time_error)
          report_mismatch($sformatf("time_error %b, want %b", out_time_error,
                                    want.time_error));
      end
    end
  end

  initial begin
    logic [31:0] factor;
    logic [31:0] cur_time;
    logic [1:0]  lv;
    int pos;
    int dir;
    int r;
    cur_time = '0;
    pos = 0;
    dir = 1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CFG: cfg_write(dir_rows[i].addr, dir_rows[i].val);
        ROW_EDGE: send_req(OP_EDGE, dir_rows[i].a, dir_rows[i].b, dir_rows[i].val,
                           1'b0, 32'sd0, 1'b0);
        default: send_req(OP_READ, dir_rows[i].a, dir_rows[i].b, dir_rows[i].val,
                          dir_rows[i].typed, dir_rows[i].t_speed, dir_rows[i].t_err);
      endcase
    end
    cur_time = m_last_time;

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: factor = FACTOR_RESET;
        1: factor = 32'hFFFFFFFF;
        3: factor = $urandom_range(1, 1000);
        4: factor = 32'd60000;
        default: factor = $urandom;
      endcase
      if (factor == '0) factor = 32'd1;
      cfg_write(ADDR_FACTOR, factor);
      if (p == 5) cfg_write(ADDR_SPARE, $urandom);
      no_idle = (p == 7);
      gap_pct = (p == 3) ? 0 : 30;
      stall_pct = (p == 4) ? 0 : 15;
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(0, 6) == 0) begin
          r = $urandom_range(0, 9);
          if (r == 0) cur_time = cur_time;
          else if (r == 1) cur_time = $urandom;
          else if (r == 2) cur_time = cur_time + $urandom_range(1, 10);
          else cur_time = cur_time + $urandom_range(1, 2000);
          send_req(OP_READ, 1'($urandom), 1'($urandom), cur_time, 1'b0, 32'sd0, 1'b0);
        end else begin
          if ($urandom_range(0, 9) == 0) begin
            lv = 2'($urandom);
          end else begin
            if ($urandom_range(0, 9) == 0) dir = -dir;
            pos = (pos + dir + 4) % 4;
            lv = GRAY[pos];
          end
          send_req(OP_EDGE, lv[1], lv[0], $urandom, 1'b0, 32'sd0, 1'b0);
        end
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (speed_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("quadrature_speed_meter_tb: clean");
    end else begin
      $display("quadrature_speed_meter_tb: errors");
    end
    $finish;
  end

endmodule

/* quadrature_speed_meter.f */
+incdir+hw/rtl
hw/rtl/qsm_pkg.sv
hw/rtl/qsm_ctrl.sv
hw/rtl/qsm_dp.sv
hw/rtl/quadrature_speed_meter.sv
dv/quadrature_speed_meter_tb.sv
